@@ sv/spr_pkg.sv @@
// Shared constants and types for the status packet receiver.
package spr_pkg;

   localparam int MAX_PACKET = 32;
   localparam int POS_W      = $clog2(MAX_PACKET);
   localparam int END_W      = 9;

   localparam logic [7:0] HEADER_BYTE = 8'hFF;
   localparam int         LEN_OFFSET  = 3;
   localparam int         SUM_START   = 2;
   localparam int         ID_POS      = 2;
   localparam int         ERR_POS     = 4;
   localparam int         PARAM1_POS  = 5;
   localparam int         PARAM2_POS  = 6;

   localparam int RSP_DATA_W = 40;

   typedef enum logic [2:0] {
      EV_IGNORED    = 3'd0,
      EV_TAKEN      = 3'd1,
      EV_BAD_HEADER = 3'd2,
      EV_CHECKSUM   = 3'd3,
      EV_TOO_LONG   = 3'd4,
      EV_ACCEPTED   = 3'd5
   } event_type;

endpackage

@@ sv/status_packet_receiver.sv @@
// Status packet framer for a half-duplex servo bus, one byte per transfer.
//
// Channel | Direction | tdata                                   | tuser
// req_    | in        | rx_byte                                 | command
// rsp_    | out       | pending, id, dev error, param 1, param 2 | event
//
// Each byte is parsed combinationally between the request and the result register.
// A new byte is taken every cycle; a two-entry output (register plus skid) takes
// one more byte while a result stalls, then req_tready drops.
// Synchronous reset clears the parser state, the pending flag and the valid flags of both output slots.
// A result is registered in the output register, or in the skid slot while the output stalls.
module status_packet_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [0:0]  req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [0] packet_pending, [8:1] packet_id,
                                    // [16:9] device_error, [24:17] param_first,
                                    // [32:25] param_second, [39:33] zero
   output logic [2:0]  rsp_tuser    // [2:0] event_res
);

   localparam int PW = spr_pkg::POS_W;
   localparam int EW = spr_pkg::END_W;

   logic          capturing_ff, capturing_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [EW-1:0] end_ff, end_in;
   logic [7:0]    sum_ff, sum_in;
   logic          pending_ff, pending_in;
   logic [7:0]    id_ff, id_in;
   logic [7:0]    err_ff, err_in;
   logic [7:0]    p1_ff, p1_in;
   logic [7:0]    p2_ff, p2_in;

   logic                            out_valid_ff, skid_valid_ff;
   logic [spr_pkg::RSP_DATA_W-1:0] out_data_ff, skid_data_ff, new_data;
   logic [2:0]                      out_user_ff, skid_user_ff;
   spr_pkg::event_type              ev;

   logic          accept, pop;
   logic [7:0]    b;
   logic [PW-1:0] pos;
   logic [7:0]    sum;
   logic [EW-1:0] len_end;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;
   assign b          = req_tdata;
   assign len_end    = {{(EW-8){1'b0}}, b} + EW'(spr_pkg::LEN_OFFSET);

   always_comb begin
      capturing_in = capturing_ff;
      pos_in       = pos_ff;
      end_in       = end_ff;
      sum_in       = sum_ff;
      pending_in   = pending_ff;
      id_in        = id_ff;
      err_in       = err_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      ev           = spr_pkg::EV_IGNORED;
      pos          = pos_ff;
      sum          = sum_ff;
      if (req_tuser[0]) begin
         pending_in = 1'b0;
      end else if (capturing_ff || !pending_ff) begin
         // start a fresh capture when idle
         if (!capturing_ff) begin
            pos = '0;
            sum = '0;
         end
         capturing_in = 1'b1;
         if (pos < PW'(spr_pkg::SUM_START)) begin
            if (b != spr_pkg::HEADER_BYTE) begin
               capturing_in = 1'b0;
               pos_in       = '0;
               sum_in       = sum;
               ev           = spr_pkg::EV_BAD_HEADER;
            end else begin
               pos_in = pos + PW'(1);
               sum_in = sum;
               ev     = spr_pkg::EV_TAKEN;
            end
         end else begin
            if (pos == PW'(spr_pkg::ID_POS))     id_in = b;
            if (pos == PW'(spr_pkg::ERR_POS))    err_in = b;
            if (pos == PW'(spr_pkg::PARAM1_POS)) p1_in = b;
            if (pos == PW'(spr_pkg::PARAM2_POS)) p2_in = b;
            if (pos == PW'(spr_pkg::LEN_OFFSET)) begin
               end_in = len_end;
            end
            if (pos == PW'(spr_pkg::LEN_OFFSET) &&
                len_end > EW'(spr_pkg::MAX_PACKET - 1)) begin
               capturing_in = 1'b0;
               pos_in       = '0;
               sum_in       = sum;
               ev           = spr_pkg::EV_TOO_LONG;
            end else if (pos >= PW'(spr_pkg::LEN_OFFSET) &&
                         {{(EW-PW){1'b0}}, pos} == end_in) begin
               capturing_in = 1'b0;
               pos_in       = '0;
               sum_in       = sum;
               if (b == ~sum) begin
                  pending_in = 1'b1;
                  ev         = spr_pkg::EV_ACCEPTED;
               end else begin
                  pending_in = 1'b0;
                  ev         = spr_pkg::EV_CHECKSUM;
               end
            end else begin
               sum_in = sum + b;
               pos_in = pos + PW'(1);
               ev     = spr_pkg::EV_TAKEN;
            end
         end
      end
   end

   assign new_data = {7'd0, p2_in, p1_in, (pending_in ? err_in : 8'd0), id_in, pending_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         capturing_ff  <= 1'b0;
         pos_ff        <= '0;
         end_ff        <= '0;
         sum_ff        <= '0;
         pending_ff    <= 1'b0;
         id_ff         <= '0;
         err_ff        <= '0;
         p1_ff         <= '0;
         p2_ff         <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            capturing_ff <= capturing_in;
            pos_ff       <= pos_in;
            end_ff       <= end_in;
            sum_ff       <= sum_in;
            pending_ff   <= pending_in;
            id_ff        <= id_in;
            err_ff       <= err_in;
            p1_ff        <= p1_in;
            p2_ff        <= p2_in;
         end
         if (skid_valid_ff) begin
            // drain the skid slot into the output register
            if (pop) begin
               out_data_ff   <= skid_data_ff;
               out_user_ff   <= skid_user_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (accept) begin
            if (!out_valid_ff || pop) begin
               out_data_ff  <= new_data;
               out_user_ff  <= ev;
               out_valid_ff <= 1'b1;
            end else begin
               skid_data_ff  <= new_data;
               skid_user_ff  <= ev;
               skid_valid_ff <= 1'b1;
            end
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

@@ sv/spr_checker.sv @@
// Port-level checks for the status packet receiver, bound to the top level.
module spr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == spr_pkg::EV_ACCEPTED |-> rsp_tdata[0])
      else $error("accepted packet not pending");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == spr_pkg::EV_CHECKSUM |-> !rsp_tdata[0])
      else $error("checksum error left packet pending");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[16:9] == 8'd0)
      else $error("device error shown with nothing pending");

endmodule

bind status_packet_receiver spr_checker u_spr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
